>>> design/lsm_pkg.sv
// Shared types and constants for the line substring matcher.
`default_nettype none
package lsm_pkg;

	// Item codes on the text channel
	localparam logic [1:0] FUNC_CHAR = 2'd0;
	localparam logic [1:0] FUNC_EOL  = 2'd1;
	localparam logic [1:0] FUNC_EOT  = 2'd2;

	// Configuration register indexes
	localparam int unsigned CFG_INDEX_W = 4;
	localparam int unsigned CFG_DATA_W  = 64;
	localparam logic [CFG_INDEX_W-1:0] REG_PAT_LEN  = 4'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_PAT_LOW  = 4'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_PAT_MID  = 4'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_PAT_HIGH = 4'd3;

	// Field widths fixed by the channel format
	localparam int unsigned PAT_LEN_W     = 5;
	localparam int unsigned PAT_REG_CHARS = 23;
	localparam int unsigned PAT_HIGH_W    = 56;
	localparam int unsigned LINE_INDEX_W  = 16;
	localparam int unsigned COUNT_W       = 17;

	typedef logic [PAT_REG_CHARS-1:0][7:0] pat_chars_t;

	// Per-item control broadcast to the window and line tracker
	typedef struct packed {
		logic adv;
		logic is_char;
		logic is_eol;
		logic is_eot;
	} step_ctl_t;

	typedef struct packed {
		logic                    is_summary;
		logic [LINE_INDEX_W-1:0] line_index;
		logic [COUNT_W-1:0]      match_count;
		logic                    none_found;
		logic                    line_overflow;
	} result_t;

endpackage
`default_nettype wire

>>> design/lsm_if.sv
// Channel interfaces: text input, report output and configuration writes.
`default_nettype none
interface lsm_in_if import lsm_pkg::*; ();
	logic       valid;
	logic       ready;
	logic [1:0] func;
	logic [7:0] char_byte;
	modport source(output valid, func, char_byte, input ready);
	modport sink(input valid, func, char_byte, output ready);
endinterface

interface lsm_out_if import lsm_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic                    is_summary;
	logic [LINE_INDEX_W-1:0] line_index;
	logic [COUNT_W-1:0]      match_count;
	logic                    none_found;
	logic                    line_overflow;
	modport source(output valid, is_summary, line_index, match_count, none_found,
		line_overflow, input ready);
	modport sink(input valid, is_summary, line_index, match_count, none_found,
		line_overflow, output ready);
endinterface

interface lsm_cfg_if import lsm_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic [CFG_INDEX_W-1:0] index;
	logic [CFG_DATA_W-1:0]  data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> design/lsm_cfg_regs.sv
// Pattern length and pattern character registers.
`default_nettype none
module lsm_cfg_regs import lsm_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	lsm_cfg_if.sink         cfg,
	output logic [PAT_LEN_W-1:0] pat_len,
	output pat_chars_t      pat_chars
);
	logic [PAT_LEN_W-1:0]  len_q;
	logic [CFG_DATA_W-1:0] low_q;
	logic [CFG_DATA_W-1:0] mid_q;
	logic [PAT_HIGH_W-1:0] high_q;

	assign cfg.ready = 1'b1;

	// Write the addressed register, drop unknown indexes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q  <= '0;
			low_q  <= '0;
			mid_q  <= '0;
			high_q <= '0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_PAT_LEN:  len_q  <= cfg.data[PAT_LEN_W-1:0];
				REG_PAT_LOW:  low_q  <= cfg.data;
				REG_PAT_MID:  mid_q  <= cfg.data;
				REG_PAT_HIGH: high_q <= cfg.data[PAT_HIGH_W-1:0];
				default: ;
			endcase
		end
	end

	assign pat_len   = len_q;
	assign pat_chars = {high_q, mid_q, low_q};
endmodule
`default_nettype wire

>>> design/lsm_window.sv
// Character window of the current line and its parallel compare against the pattern.
`default_nettype none
module lsm_window import lsm_pkg::*; #(
	parameter int unsigned MAX_PATTERN = 23
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  step_ctl_t       ctl,
	input  wire logic [7:0] char_byte,
	input  wire logic [PAT_LEN_W-1:0] pat_len,
	input  pat_chars_t      pat_chars,
	output logic            match
);
	localparam int unsigned CNT_W = $clog2(MAX_PATTERN + 1);
	localparam int unsigned IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
	localparam int unsigned CMP_N = (MAX_PATTERN < PAT_REG_CHARS) ? MAX_PATTERN
		: PAT_REG_CHARS;

	logic [7:0]       win_q [MAX_PATTERN];
	logic [7:0]       win_n [MAX_PATTERN];
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] cnt_n;
	logic [5:0]       pos [CMP_N];
	logic [CMP_N-1:0] lane_ok;
	logic             len_ok;
	logic             cnt_ok;

	// Window after shifting in the current character, newest at entry 0
	always_comb begin
		win_n[0] = char_byte;
		for (int j = 1; j < MAX_PATTERN; j++) begin
			win_n[j] = win_q[j-1];
		end
	end

	assign cnt_n = (cnt_q == CNT_W'(MAX_PATTERN)) ? cnt_q : cnt_q + 1'b1;

	// Compare pattern char k with window entry len-1-k
	always_comb begin
		for (int k = 0; k < CMP_N; k++) begin
			pos[k]     = 6'(pat_len) - 6'(k) - 6'd1;
			lane_ok[k] = (6'(k) >= 6'(pat_len)) ||
				(win_n[pos[k][IDX_W-1:0]] == pat_chars[k]);
		end
	end

	assign len_ok = (pat_len != '0) && (7'(pat_len) <= 7'(MAX_PATTERN)) &&
		(7'(pat_len) <= 7'(PAT_REG_CHARS));
	assign cnt_ok = 6'(cnt_n) >= 6'(pat_len);
	assign match  = ctl.is_char && len_ok && cnt_ok && (&lane_ok);

	// Advance the window on a character; entries beyond the count are never compared
	always_ff @(posedge clk) begin
		if (ctl.adv && ctl.is_char) begin
			win_q <= win_n;
		end
	end

	// Track characters in the line, clear at line or text end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (ctl.adv) begin
			if (ctl.is_char) begin
				cnt_q <= cnt_n;
			end else if (ctl.is_eol || ctl.is_eot) begin
				cnt_q <= '0;
			end
		end
	end
endmodule
`default_nettype wire

>>> design/lsm_line_track.sv
// Line index, per-line hit flag, match count and overflow; forms the result item.
`default_nettype none
module lsm_line_track import lsm_pkg::*; #(
	parameter int unsigned LINE_INDEX_BITS = 16
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  step_ctl_t ctl,
	input  wire logic match,
	output logic      res_valid,
	output result_t   res
);
	logic [LINE_INDEX_BITS-1:0] line_q;
	logic [COUNT_W-1:0]         hits_q;
	logic [COUNT_W-1:0]         hits_n;
	logic                       hit_q;
	logic                       ovf_q;
	logic                       new_hit;

	assign new_hit = match && !hit_q;
	assign hits_n  = (&hits_q) ? hits_q : hits_q + 1'b1;

	// Report on the first hit of a line, summarize at text end
	always_comb begin
		res_valid         = new_hit || ctl.is_eot;
		res.is_summary    = ctl.is_eot;
		res.line_index    = ctl.is_eot ? '0 : LINE_INDEX_W'(line_q);
		res.match_count   = ctl.is_eot ? hits_q : hits_n;
		res.none_found    = ctl.is_eot && (hits_q == '0);
		res.line_overflow = ovf_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_q <= '0;
			hits_q <= '0;
			hit_q  <= 1'b0;
			ovf_q  <= 1'b0;
		end else if (ctl.adv) begin
			if (ctl.is_char) begin
				if (new_hit) begin
					hit_q  <= 1'b1;
					hits_q <= hits_n;
				end
			end else if (ctl.is_eol) begin
				hit_q <= 1'b0;
				if (&line_q) begin
					ovf_q <= 1'b1;
				end else begin
					line_q <= line_q + 1'b1;
				end
			end else if (ctl.is_eot) begin
				line_q <= '0;
				hits_q <= '0;
				hit_q  <= 1'b0;
				ovf_q  <= 1'b0;
			end
		end
	end
endmodule
`default_nettype wire

>>> design/line_substring_matcher.sv
// Top level of the line substring matcher.
// Usage: write the pattern length (register 0) and the pattern characters
// (registers 1 to 3) on cfg while the block is idle. Then stream items on text:
// a character, a line end or a text end. For each line that contains the
// pattern, report carries one item with the line index and the running match
// count, given at the first character that completes the pattern. A text end
// gives a summary item (total count, none found, line overflow) and restarts
// the line and match counters; the pattern registers keep their values.
// An accepted item is held in the input register and evaluated there; its result
// is then registered in the result register, whose output drives report.
// Throughput: one item per cycle without stalls, set by the parallel window compare.
// A stalled report holds its item; the input register still takes one more item
// and then text.ready drops until report.ready returns.
// Reset clears the pattern registers, counters and both valid flags; cfg is
// always ready.
`default_nettype none
module line_substring_matcher import lsm_pkg::*; #(
	parameter int unsigned MAX_PATTERN     = 23,
	parameter int unsigned LINE_INDEX_BITS = 16
) (
	input  wire logic clk,
	input  wire logic arst_n,
	lsm_cfg_if.sink   cfg,
	lsm_in_if.sink    text,
	lsm_out_if.source report
);
	logic                 valid_s1;
	logic [1:0]           func_s1;
	logic [7:0]           char_s1;
	logic                 adv;
	step_ctl_t            ctl;
	logic [PAT_LEN_W-1:0] pat_len;
	pat_chars_t           pat_chars;
	logic                 match;
	logic                 res_valid;
	result_t              res;
	logic                 out_valid_q;
	result_t              out_q;

	// Move the held item when the result register can take it
	assign adv        = valid_s1 && (!out_valid_q || report.ready);
	assign text.ready = !valid_s1 || adv;

	always_comb begin
		ctl.adv     = adv;
		ctl.is_char = valid_s1 && (func_s1 == FUNC_CHAR);
		ctl.is_eol  = valid_s1 && (func_s1 == FUNC_EOL);
		ctl.is_eot  = valid_s1 && (func_s1 == FUNC_EOT);
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text.valid && text.ready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (text.valid && text.ready) begin
			func_s1 <= text.func;
			char_s1 <= text.char_byte;
		end
	end

	lsm_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.pat_len   (pat_len),
		.pat_chars (pat_chars)
	);

	lsm_window #(
		.MAX_PATTERN (MAX_PATTERN)
	) u_window (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.char_byte (char_s1),
		.pat_len   (pat_len),
		.pat_chars (pat_chars),
		.match     (match)
	);

	lsm_line_track #(
		.LINE_INDEX_BITS (LINE_INDEX_BITS)
	) u_track (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.match     (match),
		.res_valid (res_valid),
		.res       (res)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && res_valid) begin
			out_valid_q <= 1'b1;
		end else if (report.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && res_valid) begin
			out_q <= res;
		end
	end

	assign report.valid         = out_valid_q;
	assign report.is_summary    = out_q.is_summary;
	assign report.line_index    = out_q.line_index;
	assign report.match_count   = out_q.match_count;
	assign report.none_found    = out_q.none_found;
	assign report.line_overflow = out_q.line_overflow;

`ifndef SYNTHESIS
	a_eot_gives_summary: assert property (@(posedge clk) disable iff (!arst_n)
		adv && ctl.is_eot |=> out_valid_q && out_q.is_summary)
		else $error("text end did not produce a summary item");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !report.ready |-> !adv)
		else $error("held item advanced over a stalled result");

	a_none_found: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.is_summary |-> res.none_found == (res.match_count == '0))
		else $error("none_found disagrees with match count");

	a_one_kind: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> $onehot0({ctl.is_char, ctl.is_eol, ctl.is_eot}))
		else $error("item decoded to more than one kind");
`endif
endmodule
`default_nettype wire
